// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HUFF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define HUFF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define HUFF_ASSERT(lbl, prop, msg)
`define HUFF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/huff_pkg.sv =====
// Types and codes of the Huffman coder
`timescale 1ns / 1ps
`default_nettype none
package huff_pkg;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_BUILD  = 2'd1;
   localparam logic [1:0] OP_ENCODE = 2'd2;
   localparam logic [1:0] OP_DECODE = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_CODE   = 2'd1;
   localparam logic [1:0] ST_NOT_BUILT = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  symbol;
      logic [23:0] weight;
      logic        code_bit;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [47:0] code_bits;
      logic [5:0]  code_length;
      logic [7:0]  decoded_symbol;
   } rsp_type;

   typedef struct packed {
      logic take;
      logic build_init;
      logic copy_wr;
      logic merge_init;
      logic scan_step;
      logic scan_drain;
      logic kill_a;
      logic kill_b;
      logic make_node;
      logic walk_init;
      logic walk_rd;
      logic walk_left;
      logic walk_right;
      logic build_fail;
      logic build_done;
      logic exec;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       slot_free;
      logic       copy_last;
      logic       few_used;
      logic       scan_last;
      logic       merge_last;
      logic       len_over;
      logic       walk_last;
   } sts_type;

endpackage
`default_nettype wire

// ===== sv/huff_ram.sv =====
// Generic single write port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module huff_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== sv/huff_ctrl.sv =====
// Sequencer of the Huffman coder: request intake, build, encode and decode
`timescale 1ns / 1ps
`default_nettype none
module huff_ctrl import huff_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_EXEC      = 4'd1;
   localparam logic [3:0] S_CP_RD     = 4'd2;
   localparam logic [3:0] S_CP_WR     = 4'd3;
   localparam logic [3:0] S_CP_CHK    = 4'd4;
   localparam logic [3:0] S_SCAN      = 4'd5;
   localparam logic [3:0] S_DRAIN     = 4'd6;
   localparam logic [3:0] S_KILL_A    = 4'd7;
   localparam logic [3:0] S_KILL_B    = 4'd8;
   localparam logic [3:0] S_MAKE      = 4'd9;
   localparam logic [3:0] S_WALK_INIT = 4'd10;
   localparam logic [3:0] S_WALK_RD   = 4'd11;
   localparam logic [3:0] S_WALK_L    = 4'd12;
   localparam logic [3:0] S_WALK_R    = 4'd13;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_ready = !reset && (state_ff == S_IDLE) && sts.slot_free;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.take = 1'b1;
               case (sts.op)
                  OP_LOAD: state_in = S_IDLE;
                  OP_BUILD: begin
                     cmd.build_init = 1'b1;
                     state_in       = S_CP_RD;
                  end
                  default: state_in = S_EXEC;
               endcase
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_IDLE;
         end
         S_CP_RD: state_in = S_CP_WR;
         S_CP_WR: begin
            cmd.copy_wr = 1'b1;
            state_in    = sts.copy_last ? S_CP_CHK : S_CP_RD;
         end
         S_CP_CHK: begin
            if (sts.few_used) begin
               cmd.build_fail = 1'b1;
               state_in       = S_IDLE;
            end else begin
               cmd.merge_init = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            cmd.scan_drain = 1'b1;
            state_in       = S_KILL_A;
         end
         S_KILL_A: begin
            cmd.kill_a = 1'b1;
            state_in   = S_KILL_B;
         end
         S_KILL_B: begin
            cmd.kill_b = 1'b1;
            state_in   = S_MAKE;
         end
         S_MAKE: begin
            cmd.make_node = 1'b1;
            state_in      = sts.merge_last ? S_WALK_INIT : S_SCAN;
         end
         S_WALK_INIT: begin
            cmd.walk_init = 1'b1;
            state_in      = S_WALK_RD;
         end
         S_WALK_RD: begin
            cmd.walk_rd = 1'b1;
            state_in    = S_WALK_L;
         end
         S_WALK_L: begin
            if (sts.len_over) begin
               cmd.build_fail = 1'b1;
               state_in       = S_IDLE;
            end else begin
               cmd.walk_left = 1'b1;
               state_in      = S_WALK_R;
            end
         end
         S_WALK_R: begin
            cmd.walk_right = 1'b1;
            if (sts.walk_last) begin
               cmd.build_done = 1'b1;
               state_in       = S_IDLE;
            end else begin
               state_in = S_WALK_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/huff_datapath.sv =====
// Tables, tree memories, counters and result register of the Huffman coder
`timescale 1ns / 1ps
`default_nettype none
module huff_datapath import huff_pkg::*; #(
   parameter int NUM_SYMBOLS  = 256,
   parameter int MAX_CODE_LEN = 48,
   parameter int WEIGHT_BITS  = 24
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire cmd_type cmd,
   output sts_type      sts,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int SW    = $clog2(NUM_SYMBOLS);
   localparam int NODES = 2 * NUM_SYMBOLS - 1;
   localparam int NIW   = $clog2(NODES);
   localparam int NW    = WEIGHT_BITS + SW;
   localparam int LENW  = $clog2(MAX_CODE_LEN + 1);
   localparam int CW    = MAX_CODE_LEN + LENW;

   req_type                req_ff, req_in;
   logic [NUM_SYMBOLS-1:0] wvalid_ff, wvalid_in;
   logic [NUM_SYMBOLS-1:0] cvalid_ff, cvalid_in;
   logic                   built_ff, built_in;
   logic [NIW-1:0]         pos_ff, pos_in;
   logic [NIW-1:0]         root_ff, root_in;
   logic [SW-1:0]          cnt_ff, cnt_in;
   logic [SW:0]            used_ff, used_in;
   logic [SW:0]            remain_ff, remain_in;
   logic [NIW-1:0]         next_ff, next_in;
   logic [NIW-1:0]         scan_ff, scan_in;
   logic                   pend_ff, pend_in;
   logic [NIW-1:0]         pidx_ff, pidx_in;
   logic                   have1_ff, have1_in;
   logic                   have2_ff, have2_in;
   logic [NIW-1:0]         a_ff, a_in;
   logic [NIW-1:0]         b_ff, b_in;
   logic [NW-1:0]          w1_ff, w1_in;
   logic [NW-1:0]          w2_ff, w2_in;
   logic [NIW-1:0]         walk_ff, walk_in;
   logic [NIW-1:0]         rch_ff, rch_in;
   logic [MAX_CODE_LEN-1:0] pw_ff, pw_in;
   logic [LENW-1:0]        pl_ff, pl_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   w_we;
   logic [WEIGHT_BITS-1:0] w_wd, w_q, wcur;
   logic                   node_we;
   logic [NIW-1:0]         node_wa;
   logic [NW:0]            node_wd, node_q;
   logic                   ch_we;
   logic [NIW-1:0]         ch_ra;
   logic [2*NIW-1:0]       ch_q;
   logic                   path_we;
   logic [NIW-1:0]         path_wa;
   logic [CW-1:0]          path_wd, path_q, code_q;
   logic                   code_we;
   logic [SW-1:0]          code_wa;
   logic                   sym_ok_req, sym_ok_ff;
   logic [NIW-1:0]         lch, rch, child;
   logic [MAX_CODE_LEN-1:0] path_word;
   logic [LENW-1:0]        path_len;

   assign sym_ok_req = {1'b0, req_data.symbol} < 9'(NUM_SYMBOLS);
   assign sym_ok_ff  = {1'b0, req_ff.symbol} < 9'(NUM_SYMBOLS);
   assign w_we       = cmd.take && (req_data.operation == OP_LOAD) && sym_ok_req;
   assign w_wd       = WEIGHT_BITS'(req_data.weight);
   assign wcur       = wvalid_ff[cnt_ff] ? w_q : '0;
   assign lch        = ch_q[2*NIW-1:NIW];
   assign rch        = ch_q[NIW-1:0];
   assign child      = req_ff.code_bit ? rch : lch;
   assign path_word  = path_q[CW-1:LENW];
   assign path_len   = path_q[LENW-1:0];
   assign ch_ra      = cmd.walk_rd ? walk_ff : pos_ff;

   assign sts.op         = req_data.operation;
   assign sts.slot_free  = !rsp_valid_ff || rsp_ready;
   assign sts.copy_last  = cnt_ff == SW'(NUM_SYMBOLS - 1);
   assign sts.few_used   = used_ff < (SW+1)'(2);
   assign sts.scan_last  = scan_ff == next_ff - NIW'(1);
   assign sts.merge_last = remain_ff == (SW+1)'(1);
   assign sts.len_over   = path_len >= LENW'(MAX_CODE_LEN);
   assign sts.walk_last  = walk_ff == NIW'(NUM_SYMBOLS);

   always_comb begin
      req_in       = req_ff;
      wvalid_in    = wvalid_ff;
      cvalid_in    = cvalid_ff;
      built_in     = built_ff;
      pos_in       = pos_ff;
      root_in      = root_ff;
      cnt_in       = cnt_ff;
      used_in      = used_ff;
      remain_in    = remain_ff;
      next_in      = next_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      pidx_in      = pidx_ff;
      have1_in     = have1_ff;
      have2_in     = have2_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      w1_in        = w1_ff;
      w2_in        = w2_ff;
      walk_in      = walk_ff;
      rch_in       = rch_ff;
      pw_in        = pw_ff;
      pl_in        = pl_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      node_we      = 1'b0;
      node_wa      = '0;
      node_wd      = '0;
      ch_we        = 1'b0;
      path_we      = 1'b0;
      path_wa      = '0;
      path_wd      = '0;
      code_we      = 1'b0;
      code_wa      = '0;

      if (cmd.take) begin
         req_in = req_data;
      end
      if (w_we) begin
         wvalid_in[req_data.symbol[SW-1:0]] = 1'b1;
      end
      if (cmd.build_init) begin
         cvalid_in = '0;
         built_in  = 1'b0;
         pos_in    = '0;
         root_in   = '0;
         cnt_in    = '0;
         used_in   = '0;
      end
      if (cmd.copy_wr) begin
         node_we = 1'b1;
         node_wa = NIW'(cnt_ff);
         node_wd = {|wcur, NW'(wcur)};
         used_in = used_ff + (SW+1)'(|wcur);
         cnt_in  = cnt_ff + SW'(1);
      end
      if (cmd.merge_init || cmd.make_node) begin
         scan_in  = '0;
         pend_in  = 1'b0;
         have1_in = 1'b0;
         have2_in = 1'b0;
      end
      if (cmd.merge_init) begin
         next_in   = NIW'(NUM_SYMBOLS);
         remain_in = used_ff - (SW+1)'(1);
      end
      if (cmd.scan_step) begin
         pend_in = 1'b1;
         pidx_in = scan_ff;
         scan_in = scan_ff + NIW'(1);
      end
      if (cmd.scan_drain) begin
         pend_in = 1'b0;
      end
      if ((cmd.scan_step || cmd.scan_drain) && pend_ff && node_q[NW]) begin
         if (!have1_ff || node_q[NW-1:0] < w1_ff) begin
            w2_in    = w1_ff;
            b_in     = a_ff;
            have2_in = have1_ff;
            w1_in    = node_q[NW-1:0];
            a_in     = pidx_ff;
            have1_in = 1'b1;
         end else if (!have2_ff || node_q[NW-1:0] < w2_ff) begin
            w2_in    = node_q[NW-1:0];
            b_in     = pidx_ff;
            have2_in = 1'b1;
         end
      end
      if (cmd.kill_a) begin
         node_we = 1'b1;
         node_wa = a_ff;
         node_wd = {1'b0, w1_ff};
      end
      if (cmd.kill_b) begin
         node_we = 1'b1;
         node_wa = b_ff;
         node_wd = {1'b0, w2_ff};
      end
      if (cmd.make_node) begin
         node_we   = 1'b1;
         node_wa   = next_ff;
         node_wd   = {1'b1, w1_ff + w2_ff};
         ch_we     = 1'b1;
         next_in   = next_ff + NIW'(1);
         remain_in = remain_ff - (SW+1)'(1);
      end
      if (cmd.walk_init) begin
         root_in = next_ff - NIW'(1);
         walk_in = next_ff - NIW'(1);
         path_we = 1'b1;
         path_wa = next_ff - NIW'(1);
         path_wd = '0;
      end
      if (cmd.walk_left) begin
         rch_in  = rch;
         pw_in   = path_word;
         pl_in   = path_len;
         path_we = 1'b1;
         path_wa = lch;
         path_wd = {path_word[MAX_CODE_LEN-2:0], 1'b0, path_len + LENW'(1)};
         if (lch < NIW'(NUM_SYMBOLS)) begin
            code_we                 = 1'b1;
            code_wa                 = lch[SW-1:0];
            cvalid_in[lch[SW-1:0]]  = 1'b1;
         end
      end
      if (cmd.walk_right) begin
         path_we = 1'b1;
         path_wa = rch_ff;
         path_wd = {pw_ff[MAX_CODE_LEN-2:0], 1'b1, pl_ff + LENW'(1)};
         walk_in = walk_ff - NIW'(1);
         if (rch_ff < NIW'(NUM_SYMBOLS)) begin
            code_we                   = 1'b1;
            code_wa                   = rch_ff[SW-1:0];
            cvalid_in[rch_ff[SW-1:0]] = 1'b1;
         end
      end
      if (cmd.build_fail) begin
         cvalid_in    = '0;
         built_in     = 1'b0;
         pos_in       = '0;
         root_in      = '0;
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         rsp_in.status = ST_NOT_BUILT;
      end
      if (cmd.build_done) begin
         built_in     = 1'b1;
         pos_in       = root_ff;
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         rsp_in.status = ST_OK;
      end
      if (cmd.exec) begin
         rsp_in = '0;
         if (req_ff.operation == OP_ENCODE) begin
            rsp_valid_in = 1'b1;
            if (!built_ff) begin
               rsp_in.status = ST_NOT_BUILT;
            end else if (!sym_ok_ff || !cvalid_ff[req_ff.symbol[SW-1:0]]) begin
               rsp_in.status = ST_NO_CODE;
            end else begin
               rsp_in.code_bits   = 48'(code_q[CW-1:LENW]);
               rsp_in.code_length = 6'(code_q[LENW-1:0]);
            end
         end else if (!built_ff || pos_ff < NIW'(NUM_SYMBOLS) ||
                      pos_ff >= NIW'(NODES)) begin
            rsp_valid_in  = 1'b1;
            rsp_in.status = ST_NOT_BUILT;
         end else if (child < NIW'(NUM_SYMBOLS)) begin
            rsp_valid_in          = 1'b1;
            rsp_in.decoded_symbol = 8'(child[SW-1:0]);
            pos_in                = root_ff;
         end else begin
            pos_in = child;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wvalid_ff    <= '0;
         cvalid_ff    <= '0;
         built_ff     <= 1'b0;
         pos_ff       <= '0;
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wvalid_ff    <= wvalid_in;
         cvalid_ff    <= cvalid_in;
         built_ff     <= built_in;
         pos_ff       <= pos_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff    <= req_in;
      cnt_ff    <= cnt_in;
      used_ff   <= used_in;
      remain_ff <= remain_in;
      next_ff   <= next_in;
      scan_ff   <= scan_in;
      pend_ff   <= pend_in;
      pidx_ff   <= pidx_in;
      have1_ff  <= have1_in;
      have2_ff  <= have2_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      w1_ff     <= w1_in;
      w2_ff     <= w2_in;
      walk_ff   <= walk_in;
      rch_ff    <= rch_in;
      pw_ff     <= pw_in;
      pl_ff     <= pl_in;
      rsp_ff    <= rsp_in;
   end

   huff_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(NUM_SYMBOLS)) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (req_data.symbol[SW-1:0]),
      .wr_data (w_wd),
      .rd_addr (cnt_ff),
      .rd_data (w_q)
   );

   huff_ram #(.WIDTH(NW + 1), .DEPTH(NODES)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_wa),
      .wr_data (node_wd),
      .rd_addr (scan_ff),
      .rd_data (node_q)
   );

   huff_ram #(.WIDTH(2 * NIW), .DEPTH(NODES)) u_child_ram (
      .clock   (clock),
      .wr_en   (ch_we),
      .wr_addr (next_ff),
      .wr_data ({a_ff, b_ff}),
      .rd_addr (ch_ra),
      .rd_data (ch_q)
   );

   huff_ram #(.WIDTH(CW), .DEPTH(NODES)) u_path_ram (
      .clock   (clock),
      .wr_en   (path_we),
      .wr_addr (path_wa),
      .wr_data (path_wd),
      .rd_addr (walk_ff),
      .rd_data (path_q)
   );

   huff_ram #(.WIDTH(CW), .DEPTH(NUM_SYMBOLS)) u_code_ram (
      .clock   (clock),
      .wr_en   (code_we),
      .wr_addr (code_wa),
      .wr_data (path_wd),
      .rd_addr (req_data.symbol[SW-1:0]),
      .rd_data (code_q)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ===== sv/huffman_code_build_encode_decode_unit.sv =====
// Top level of the byte-symbol Huffman coder
//
// Requests arrive on req_valid/req_ready with a req_type payload; results leave
// on rsp_valid/rsp_ready as rsp_type from a single output register.
// Load: writes the weight of a symbol and gives no result. Encode: the code
// table is read at the accept edge and the result is registered in the
// cycle after. Decode: one request per code bit through the child memory;
// a result at a leaf, or a not-built status. Build: copies NUM_SYMBOLS
// weights, then per merge one scan over all nodes made so far, live or
// dead, then walks each internal node (read, left, right) to assign codes;
// under two used symbols or an over-long code fail it with a not-built status.
// A request is taken only when the controller is idle and the output
// register is empty or being emptied, so a stalled receiver holds off input.
// Reset clears weights, codes, the built flag and the decode position;
// no request is taken during reset, and the block accepts one as soon as
// reset drops.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module huffman_code_build_encode_decode_unit import huff_pkg::*; #(
   parameter int NUM_SYMBOLS  = 256,
   parameter int MAX_CODE_LEN = 48,
   parameter int WEIGHT_BITS  = 24
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   cmd_type cmd;
   sts_type sts;

   huff_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   huff_datapath #(
      .NUM_SYMBOLS  (NUM_SYMBOLS),
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `HUFF_ASSERT(a_node_port, $onehot0({cmd.copy_wr, cmd.kill_a, cmd.kill_b, cmd.make_node}), "node write conflict")
   `HUFF_ASSERT(a_rsp_src, $onehot0({cmd.build_fail, cmd.build_done, cmd.exec}), "two result sources")
   `HUFF_ASSERT(a_slot, !(req_valid && req_ready) || !rsp_valid || rsp_ready, "request taken while result blocked")
   `HUFF_ASSERT_NEXT(a_done_rsp, cmd.build_done || cmd.build_fail, rsp_valid, "build gave no result")

endmodule
`default_nettype wire
